[rtl/assert_macros.svh]
// assertion macros shared by the rtl files
// each macro is checked on the rising edge of clk, held off while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define KWM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: assertion failed");

`define KWM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

`define KWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`else

`define KWM_ASSERT(label, prop)
`define KWM_ASSERT_IMPL(label, ante, cons)
`define KWM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[rtl/kwm_pkg.sv]
package kwm_pkg;

  localparam int LISTS      = 8;
  localparam int LIST_DEPTH = 128;
  localparam int QDEPTH     = 2;

  localparam int DATA_W = 32;
  localparam int SEL_W  = 3;
  localparam int FROM_W = 3;
  localparam int STAT_W = 2;

  localparam int LIST_W = (LISTS > 1) ? $clog2(LISTS) : 1;
  localparam int PTR_W  = $clog2(LIST_DEPTH);
  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int SUM_W  = PTR_W + 1;
  localparam int ADDR_W = $clog2(LISTS * LIST_DEPTH);
  localparam int QP_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QC_W   = $clog2(QDEPTH + 1);

  localparam int TDATA_IN_W  = ((SEL_W + DATA_W + 7) / 8) * 8;
  localparam int TDATA_OUT_W = ((DATA_W + FROM_W + 7) / 8) * 8;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // one classified item waiting for the execution side
  typedef struct packed {
    logic              is_pop;
    logic              sel_ok;
    logic [LIST_W-1:0] list;
    logic [DATA_W-1:0] data;
  } op_t;

  // word address of a list element in the shared store
  function automatic logic [ADDR_W-1:0] mem_addr(input logic [LIST_W-1:0] list,
                                                 input logic [PTR_W-1:0]  ptr);
    mem_addr = ADDR_W'(ADDR_W'(list) * ADDR_W'(LIST_DEPTH)) + ADDR_W'(ptr);
  endfunction

endpackage

[rtl/kwm_front.sv]
`include "assert_macros.svh"

module kwm_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     func,
  input  logic [kwm_pkg::SEL_W-1:0]  list_sel,
  input  logic [kwm_pkg::DATA_W-1:0] data_in,
  output logic                     q_valid,
  input  logic                     q_ready,
  output kwm_pkg::op_t             q_op
);

  kwm_pkg::op_t                  q_mem [kwm_pkg::QDEPTH];
  logic [kwm_pkg::QP_W-1:0]      wr_ptr;
  logic [kwm_pkg::QP_W-1:0]      rd_ptr;
  logic [kwm_pkg::QC_W-1:0]      count;
  kwm_pkg::op_t                  op_in;
  logic                          push;
  logic                          pop;

  always_comb begin
    op_in.is_pop = func;
    op_in.sel_ok = (int'(list_sel) < kwm_pkg::LISTS);
    op_in.list   = op_in.sel_ok ? kwm_pkg::LIST_W'(list_sel) : '0;
    op_in.data   = data_in;
  end

  assign in_ready = (count != kwm_pkg::QC_W'(kwm_pkg::QDEPTH));
  assign q_valid  = (count != '0);
  assign q_op     = q_mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == kwm_pkg::QP_W'(kwm_pkg::QDEPTH - 1)) ?
                  '0 : wr_ptr + kwm_pkg::QP_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == kwm_pkg::QP_W'(kwm_pkg::QDEPTH - 1)) ?
                  '0 : rd_ptr + kwm_pkg::QP_W'(1);
      end
      if (push && !pop) begin
        count <= count + kwm_pkg::QC_W'(1);
      end else if (pop && !push) begin
        count <= count - kwm_pkg::QC_W'(1);
      end
    end
  end

  `KWM_ASSERT(a_count_bound, count <= kwm_pkg::QC_W'(kwm_pkg::QDEPTH))
  `KWM_ASSERT_NEXT(a_push_grows, push && !pop, count == $past(count) + kwm_pkg::QC_W'(1))
  `KWM_ASSERT_NEXT(a_pop_shrinks, pop && !push, count == $past(count) - kwm_pkg::QC_W'(1))

endmodule

[rtl/kwm_back.sv]
`include "assert_macros.svh"

module kwm_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  kwm_pkg::op_t                q_op,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [kwm_pkg::DATA_W-1:0]  out_data,
  output logic [kwm_pkg::FROM_W-1:0]  out_list,
  output logic [kwm_pkg::STAT_W-1:0]  out_status
);

  typedef enum logic {B_EXEC, B_FILL} state_t;

  state_t                         state;
  logic [kwm_pkg::PTR_W-1:0]      head_ptr [kwm_pkg::LISTS];
  logic [kwm_pkg::CNT_W-1:0]      cnt      [kwm_pkg::LISTS];
  logic [kwm_pkg::DATA_W-1:0]     head_val [kwm_pkg::LISTS];
  logic [kwm_pkg::DATA_W-1:0]     mem      [kwm_pkg::LISTS * kwm_pkg::LIST_DEPTH];
  logic [kwm_pkg::DATA_W-1:0]     rd_data;
  logic [kwm_pkg::LIST_W-1:0]     fill_list;

  logic                           take;
  logic                           found;
  logic [kwm_pkg::LIST_W-1:0]     best;
  logic [kwm_pkg::DATA_W-1:0]     best_val;
  logic [kwm_pkg::PTR_W-1:0]      ptr_inc;
  logic [kwm_pkg::SUM_W-1:0]      tail_sum;
  logic [kwm_pkg::PTR_W-1:0]      tail;
  logic                           app_ok;
  logic                           wr_en;
  logic                           rd_en;
  logic [kwm_pkg::DATA_W-1:0]     res_data;
  logic [kwm_pkg::FROM_W-1:0]     res_list;
  logic [kwm_pkg::STAT_W-1:0]     res_status;

  assign take    = (state == B_EXEC) && q_valid && (!out_valid || out_ready);
  assign q_ready = take;

  // smallest head among non-empty lists, lowest list wins a tie
  always_comb begin
    found    = 1'b0;
    best     = '0;
    best_val = '0;
    for (int i = 0; i < kwm_pkg::LISTS; i++) begin
      if (cnt[i] != '0) begin
        if (!found || ($signed(head_val[i]) < $signed(best_val))) begin
          found    = 1'b1;
          best     = kwm_pkg::LIST_W'(i);
          best_val = head_val[i];
        end
      end
    end
  end

  always_comb begin
    ptr_inc  = (head_ptr[best] == kwm_pkg::PTR_W'(kwm_pkg::LIST_DEPTH - 1)) ?
               '0 : head_ptr[best] + kwm_pkg::PTR_W'(1);
    tail_sum = kwm_pkg::SUM_W'(head_ptr[q_op.list]) + kwm_pkg::SUM_W'(cnt[q_op.list]);
    tail     = (tail_sum >= kwm_pkg::SUM_W'(kwm_pkg::LIST_DEPTH)) ?
               kwm_pkg::PTR_W'(tail_sum - kwm_pkg::SUM_W'(kwm_pkg::LIST_DEPTH)) :
               kwm_pkg::PTR_W'(tail_sum);
    app_ok   = q_op.sel_ok && (cnt[q_op.list] != kwm_pkg::CNT_W'(kwm_pkg::LIST_DEPTH));
    wr_en    = take && !q_op.is_pop && app_ok;
    rd_en    = take && q_op.is_pop && found && (cnt[best] != kwm_pkg::CNT_W'(1));
  end

  // result fields for the transaction taken this cycle
  always_comb begin
    res_data   = '0;
    res_list   = '0;
    res_status = kwm_pkg::ST_OK;
    if (!q_op.is_pop) begin
      if (!app_ok) begin
        res_status = kwm_pkg::ST_FULL;
      end
    end else if (!found) begin
      res_status = kwm_pkg::ST_EMPTY;
    end else begin
      res_data = best_val;
      res_list = kwm_pkg::FROM_W'(best);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[kwm_pkg::mem_addr(q_op.list, tail)] <= q_op.data;
    end
    if (rd_en) begin
      rd_data <= mem[kwm_pkg::mem_addr(best, ptr_inc)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_EXEC;
      out_valid <= 1'b0;
      for (int i = 0; i < kwm_pkg::LISTS; i++) begin
        head_ptr[i] <= '0;
        cnt[i]      <= '0;
        head_val[i] <= '0;
      end
    end else begin
      if (take) begin
        out_valid  <= 1'b1;
        out_data   <= res_data;
        out_list   <= res_list;
        out_status <= res_status;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_EXEC: begin
          if (take) begin
            if (!q_op.is_pop) begin
              if (app_ok) begin
                cnt[q_op.list] <= cnt[q_op.list] + kwm_pkg::CNT_W'(1);
                if (cnt[q_op.list] == '0) begin
                  head_val[q_op.list] <= q_op.data;
                end
              end
            end else if (found) begin
              head_ptr[best] <= ptr_inc;
              cnt[best]      <= cnt[best] - kwm_pkg::CNT_W'(1);
              if (rd_en) begin
                fill_list <= best;
                state     <= B_FILL;
              end
            end
          end
        end
        B_FILL: begin
          head_val[fill_list] <= rd_data;
          state               <= B_EXEC;
        end
        default: begin
          state <= B_EXEC;
        end
      endcase
    end
  end

  `KWM_ASSERT_NEXT(a_fill_one_cycle, state == B_FILL, state == B_EXEC)
  `KWM_ASSERT_IMPL(a_no_take_in_fill, state == B_FILL, !q_ready)
  `KWM_ASSERT_IMPL(a_fill_list_live, state == B_FILL, cnt[fill_list] != '0)

endmodule

[rtl/k_way_list_merger.sv]
// channel  dir  tdata (low bit up)                       tuser
// s_axis   in   list_sel[2:0], data_in[34:3], zero pad    func[0]
// m_axis   out  data_out[31:0], from_list[34:32], pad     status[1:0]
//
// an append, or a pop that finds every list empty or takes its list's last
// element, completes in the execution state; any other pop then passes
// through the fill state, which loads the store read of the popped list's next element
// the front queue holds two transactions so input acceptance continues while
// the execution stage works or the result register waits for m_tready
// rst is synchronous: all lists empty, heads and pointers zero, store untouched
// one result transaction per input transaction, in input order
module k_way_list_merger (
  input  logic                                 clk,
  input  logic                                 rst,
  // input stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [kwm_pkg::TDATA_IN_W-1:0]       s_tdata,   // list_sel, data_in
  input  logic [0:0]                           s_tuser,   // func
  // result stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [kwm_pkg::TDATA_OUT_W-1:0]      m_tdata,   // data_out, from_list
  output logic [kwm_pkg::STAT_W-1:0]           m_tuser    // status
);

  logic                            q_valid;
  logic                            q_ready;
  kwm_pkg::op_t                    q_op;
  logic [kwm_pkg::DATA_W-1:0]      out_data;
  logic [kwm_pkg::FROM_W-1:0]      out_list;

  // front: accept, check the list number, queue
  kwm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .func     (s_tuser[0]),
    .list_sel (s_tdata[kwm_pkg::SEL_W-1:0]),
    .data_in  (s_tdata[kwm_pkg::SEL_W +: kwm_pkg::DATA_W]),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_op     (q_op)
  );

  // back: list state, shared store, min of heads, result register
  kwm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_op       (q_op),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (out_data),
    .out_list   (out_list),
    .out_status (m_tuser)
  );

  // pack result, pad upper bits with zeros
  assign m_tdata = kwm_pkg::TDATA_OUT_W'({out_list, out_data});

endmodule
